### hdl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants
// Commands, phase modes, enable patterns, the result word layout and the
// per-sector sign table of the six-step commutation unit.
// ----------------------------------------------------------------------------
package ssc_pkg;

    typedef enum logic [1:0] {
        CMD_SET_DUTY  = 2'd0,
        CMD_COMMUTATE = 2'd1,
        CMD_FLOAT     = 2'd2,
        CMD_LOW_SIDES = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_LOW  = 2'd0,
        MODE_HIGH = 2'd1,
        MODE_PWM  = 2'd2
    } mode_t;

    localparam logic [2:0] SECTOR_LAST = 3'd5;

    localparam logic [5:0] EN_ALL       = 6'h3F;
    localparam logic [5:0] EN_LOW_SIDES = 6'h2A;
    localparam logic [5:0] EN_SECT_14   = 6'h35;
    localparam logic [5:0] EN_SECT_25   = 6'h1D;
    localparam logic [5:0] EN_SECT_03   = 6'h17;

    localparam int CMP_W      = 11;
    localparam int DUTY_W     = 16;
    localparam int QUOT_W     = DUTY_W + 1;
    localparam int RESULT_W   = 56;

    // Result word, lowest field in the lowest bits.
    typedef struct packed {
        logic [5:0]       pad;
        logic [2:0]       sector;
        logic             in_idle_gap;
        logic             commutation_request;
        logic [5:0]       output_enables;
        mode_t            mode_c;
        mode_t            mode_b;
        mode_t            mode_a;
        logic [CMP_W-1:0] compare_c;
        logic [CMP_W-1:0] compare_b;
        logic [CMP_W-1:0] compare_a;
    } result_t;

    // Phases that take the plus sign in a sector: bit0 A, bit1 B, bit2 C.
    function automatic logic [2:0] sign_plus(input logic [2:0] sector);
        logic [2:0] s;
        begin
            case (sector)
                3'd0:    s = 3'b100;
                3'd1:    s = 3'b101;
                3'd2:    s = 3'b001;
                3'd3:    s = 3'b011;
                3'd4:    s = 3'b010;
                3'd5:    s = 3'b110;
                default: s = 3'b000;
            endcase
            return s;
        end
    endfunction

endpackage

### hdl/ssc_compare.sv
// ----------------------------------------------------------------------------
// ssc_compare: one phase compare value
// Adds or subtracts the scaled duty around the center value and saturates
// the result into the timer range.
// ----------------------------------------------------------------------------
module ssc_compare #(
    parameter int CENTER_VALUE = 1023,
    parameter int PERIOD_MAX   = 2047
) (
    input  logic signed [ssc_pkg::QUOT_W-1:0] quot,
    input  logic                              plus,
    output logic [ssc_pkg::CMP_W-1:0]         compare
);
    import ssc_pkg::*;

    localparam int SUM_W = QUOT_W + 2;
    localparam logic signed [SUM_W-1:0] CENTER = SUM_W'(CENTER_VALUE);
    localparam logic signed [SUM_W-1:0] TOP    = SUM_W'(PERIOD_MAX);

    logic signed [SUM_W-1:0] quot_ext;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        clamped;

    assign quot_ext = SUM_W'(quot);
    assign sum      = plus ? (CENTER + quot_ext) : (CENTER - quot_ext);

    always_comb
    begin
        if (sum < 0)
            clamped = '0;
        else if (sum > TOP)
            clamped = TOP;
        else
            clamped = sum;
    end

    // keep the low bits of the saturated value
    assign compare = clamped[CMP_W-1:0];

endmodule

### hdl/six_step_commutation_pwm_unit.sv
// ----------------------------------------------------------------------------
// six_step_commutation_pwm_unit: six-step commutation sequencer
// Takes duty and commutation commands and returns, per command word, the
// three center-aligned compare values, phase modes and gate enables.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                         tuser
//  s_axis    in         duty[15:0]                    cmd[1:0]
//  m_axis    out        compares, modes, enables,     -
//                       request, idle gap, sector
//
//  The state update and the compare arithmetic for a command word are
//  combinational and sit between the state registers and the result register.
//  A new word is taken every cycle while the result register is empty or
//  being drained in the same cycle, so throughput is one word per clock.
//  Reset (rst_n low, asynchronous) puts the unit in the idle gap, sector 0,
//  duty 0, all phases forced low, all enables set, no result pending.
//  A stalled result holds the output and blocks the input side.
// ----------------------------------------------------------------------------
module six_step_commutation_pwm_unit #(
    parameter int CENTER_VALUE = 1023,
    parameter int PERIOD_MAX   = 2047,
    parameter int DUTY_SHIFT   = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ssc_pkg::DUTY_W-1:0]      s_axis_tdata,  // [15:0] duty
    input  logic [1:0]                      s_axis_tuser,  // [1:0] cmd
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [10:0] compare_a, [21:11] compare_b, [32:22] compare_c,
    // [34:33] mode_a, [36:35] mode_b, [38:37] mode_c,
    // [44:39] output_enables, [45] commutation_request,
    // [46] in_idle_gap, [49:47] sector, [55:50] zero
    output logic [ssc_pkg::RESULT_W-1:0]    m_axis_tdata
);
    import ssc_pkg::*;

    // Bias that turns the arithmetic shift into truncation toward zero.
    localparam logic signed [QUOT_W-1:0] ROUND_BIAS = QUOT_W'((1 << DUTY_SHIFT) - 1);

    // Sequencer state
    logic [2:0]               sector_reg, sector_next;
    logic                     idle_reg, idle_next;
    logic [DUTY_W-1:0]        duty_reg, duty_next;
    mode_t                    mode_a_reg, mode_a_next;
    mode_t                    mode_b_reg, mode_b_next;
    mode_t                    mode_c_reg, mode_c_next;
    logic [5:0]               enable_reg, enable_next;

    // Output stage
    logic                     out_valid_reg, out_valid_next;
    result_t                  result_reg, result_next;

    cmd_t                     cmd;
    logic                     in_fire;
    logic                     request;
    logic [2:0]               sector_adv;
    logic [2:0]               plus;
    logic signed [QUOT_W-1:0] duty_ext;
    logic signed [QUOT_W-1:0] quot;
    logic [CMP_W-1:0]         cmp_a, cmp_b, cmp_c;

    // Take a word whenever the result slot is free or drains this cycle.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cmd           = cmd_t'(s_axis_tuser);

    assign sector_adv = (sector_reg >= SECTOR_LAST) ? 3'd0 : (sector_reg + 3'd1);

    // Next sequencer state for the command in the input word
    always_comb
    begin
        sector_next = sector_reg;
        idle_next   = idle_reg;
        duty_next   = duty_reg;
        mode_a_next = mode_a_reg;
        mode_b_next = mode_b_reg;
        mode_c_next = mode_c_reg;
        enable_next = enable_reg;
        request     = 1'b0;
        case (cmd)
            CMD_SET_DUTY:
            begin
                duty_next = s_axis_tdata;
            end
            CMD_COMMUTATE:
            begin
                if (idle_reg)
                begin
                    // leave the gap: advance and drive the new sector pattern
                    idle_next   = 1'b0;
                    sector_next = sector_adv;
                    request     = 1'b1;
                    case (sector_adv)
                        3'd1, 3'd4:
                        begin
                            mode_a_next = MODE_PWM;
                            mode_b_next = MODE_PWM;
                            mode_c_next = MODE_LOW;
                            enable_next = EN_SECT_14;
                        end
                        3'd2, 3'd5:
                        begin
                            mode_a_next = MODE_PWM;
                            mode_b_next = MODE_LOW;
                            mode_c_next = MODE_PWM;
                            enable_next = EN_SECT_25;
                        end
                        default:
                        begin
                            mode_a_next = MODE_LOW;
                            mode_b_next = MODE_PWM;
                            mode_c_next = MODE_PWM;
                            enable_next = EN_SECT_03;
                        end
                    endcase
                end
                else
                begin
                    // enter the floating gap, keep the sector
                    idle_next   = 1'b1;
                    mode_a_next = MODE_LOW;
                    mode_b_next = MODE_LOW;
                    mode_c_next = MODE_LOW;
                    enable_next = EN_ALL;
                end
            end
            CMD_FLOAT:
            begin
                mode_a_next = MODE_LOW;
                mode_b_next = MODE_LOW;
                mode_c_next = MODE_LOW;
                enable_next = EN_ALL;
                request     = 1'b1;
            end
            CMD_LOW_SIDES:
            begin
                mode_a_next = MODE_HIGH;
                mode_b_next = MODE_HIGH;
                mode_c_next = MODE_HIGH;
                enable_next = EN_LOW_SIDES;
                request     = 1'b1;
            end
            default:
            begin
                request = 1'b0;
            end
        endcase
    end

    // Scaled duty, truncated toward zero, from the updated duty value
    assign duty_ext = QUOT_W'($signed(duty_next));
    assign quot     = (duty_next[DUTY_W-1] ? (duty_ext + ROUND_BIAS) : duty_ext)
                      >>> DUTY_SHIFT;
    assign plus     = sign_plus(sector_next);

    ssc_compare #(
        .CENTER_VALUE (CENTER_VALUE),
        .PERIOD_MAX   (PERIOD_MAX)
    ) u_cmp_a (
        .quot    (quot),
        .plus    (plus[0]),
        .compare (cmp_a)
    );

    ssc_compare #(
        .CENTER_VALUE (CENTER_VALUE),
        .PERIOD_MAX   (PERIOD_MAX)
    ) u_cmp_b (
        .quot    (quot),
        .plus    (plus[1]),
        .compare (cmp_b)
    );

    ssc_compare #(
        .CENTER_VALUE (CENTER_VALUE),
        .PERIOD_MAX   (PERIOD_MAX)
    ) u_cmp_c (
        .quot    (quot),
        .plus    (plus[2]),
        .compare (cmp_c)
    );

    // Assemble the result word from the post-command state
    always_comb
    begin
        result_next.pad                 = '0;
        result_next.sector              = sector_next;
        result_next.in_idle_gap         = idle_next;
        result_next.commutation_request = request;
        result_next.output_enables      = enable_next;
        result_next.mode_c              = mode_c_next;
        result_next.mode_b              = mode_b_next;
        result_next.mode_a              = mode_a_next;
        result_next.compare_c           = cmp_c;
        result_next.compare_b           = cmp_b;
        result_next.compare_a           = cmp_a;
    end

    // Result slot: fill on accept, drop once taken
    always_comb
    begin
        if (in_fire)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_reg    <= 3'd0;
            idle_reg      <= 1'b1;
            duty_reg      <= '0;
            mode_a_reg    <= MODE_LOW;
            mode_b_reg    <= MODE_LOW;
            mode_c_reg    <= MODE_LOW;
            enable_reg    <= EN_ALL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                sector_reg <= sector_next;
                idle_reg   <= idle_next;
                duty_reg   <= duty_next;
                mode_a_reg <= mode_a_next;
                mode_b_reg <= mode_b_next;
                mode_c_reg <= mode_c_next;
                enable_reg <= enable_next;
            end
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_fire)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg;

`ifndef SYNTHESIS
    // The sector never leaves 0..5.
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        sector_reg <= SECTOR_LAST)
        else $error("sector out of range");

    // A stalled result blocks the input side.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");

    // A commutation taken from the gap leaves the gap and flags a request.
    a_gap_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cmd == CMD_COMMUTATE && idle_reg) |=>
            (!idle_reg && result_reg.commutation_request && m_axis_tvalid))
        else $error("gap exit not applied");

    // In the gap after a commutation the bridge floats with all enables set.
    a_gap_float: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cmd == CMD_COMMUTATE && !idle_reg) |=>
            (idle_reg && enable_reg == EN_ALL && mode_a_reg == MODE_LOW))
        else $error("gap entry not applied");
`endif

endmodule

### tb/ssc_result_checker.sv
// ----------------------------------------------------------------------------
// ssc_result_checker: commutation result predictor and comparator
// Watches both stream channels of the six-step unit, keeps its own copy of
// the sector, idle gap, duty and output pattern, predicts one result per
// accepted command word and compares it field by field with the unit.
// ----------------------------------------------------------------------------
module ssc_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [ssc_pkg::DUTY_W-1:0]    s_axis_tdata,   // [15:0] duty
    input  logic [1:0]                    s_axis_tuser,   // [1:0] cmd
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [ssc_pkg::RESULT_W-1:0]  m_axis_tdata,   // result_t, compare_a lowest
    output int                            fail_count,
    output int                            pending
);
    import ssc_pkg::*;

    localparam int CENTER   = 1023;
    localparam int CMP_MAX  = 2047;
    localparam int Q_SHIFT  = 5;

    logic [2:0]               sector_now;
    logic                     idle_gap;
    logic signed [DUTY_W-1:0] duty_held;
    mode_t                    mode_a_now, mode_b_now, mode_c_now;
    logic [5:0]               enables_now;

    result_t expected_results[$];

    function automatic logic [CMP_W-1:0] phase_compare(input int q, input bit plus);
        int v;
        v = plus ? CENTER + q : CENTER - q;
        if (v < 0)
            v = 0;
        if (v > CMP_MAX)
            v = CMP_MAX;
        return v[CMP_W-1:0];
    endfunction

    function automatic void drive_pattern(input mode_t a, input mode_t b, input mode_t c,
                                          input logic [5:0] en);
        mode_a_now  = a;
        mode_b_now  = b;
        mode_c_now  = c;
        enables_now = en;
    endfunction

    // Apply one command to the shadow state and build the result it yields.
    function automatic result_t commutate_word(input cmd_t cmd, input logic [DUTY_W-1:0] duty);
        result_t    r;
        logic       req;
        logic [2:0] plus;   // {C, B, A}
        int         q;
        req = 1'b0;
        case (cmd)
            CMD_SET_DUTY:
                duty_held = duty;
            CMD_COMMUTATE:
                if (idle_gap)
                begin
                    idle_gap   = 1'b0;
                    sector_now = (sector_now >= SECTOR_LAST) ? 3'd0 : sector_now + 3'd1;
                    case (sector_now)
                        3'd1, 3'd4: drive_pattern(MODE_PWM, MODE_PWM, MODE_LOW, EN_SECT_14);
                        3'd2, 3'd5: drive_pattern(MODE_PWM, MODE_LOW, MODE_PWM, EN_SECT_25);
                        default:    drive_pattern(MODE_LOW, MODE_PWM, MODE_PWM, EN_SECT_03);
                    endcase
                    req = 1'b1;
                end
                else
                begin
                    idle_gap = 1'b1;
                    drive_pattern(MODE_LOW, MODE_LOW, MODE_LOW, EN_ALL);
                end
            CMD_FLOAT:
            begin
                drive_pattern(MODE_LOW, MODE_LOW, MODE_LOW, EN_ALL);
                req = 1'b1;
            end
            default:
            begin
                drive_pattern(MODE_HIGH, MODE_HIGH, MODE_HIGH, EN_LOW_SIDES);
                req = 1'b1;
            end
        endcase

        case (sector_now)
            3'd0:    plus = 3'b100;
            3'd1:    plus = 3'b101;
            3'd2:    plus = 3'b001;
            3'd3:    plus = 3'b011;
            3'd4:    plus = 3'b010;
            3'd5:    plus = 3'b110;
            default: plus = 3'b000;
        endcase

        // signed division truncates toward zero, as the unit does
        q = int'(duty_held) / (1 << Q_SHIFT);

        r                     = '0;
        r.compare_a           = phase_compare(q, plus[0]);
        r.compare_b           = phase_compare(q, plus[1]);
        r.compare_c           = phase_compare(q, plus[2]);
        r.mode_a              = mode_a_now;
        r.mode_b              = mode_b_now;
        r.mode_c              = mode_c_now;
        r.output_enables      = enables_now;
        r.commutation_request = req;
        r.in_idle_gap         = idle_gap;
        r.sector              = sector_now;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            sector_now = 3'd0;
            idle_gap   = 1'b1;
            duty_held  = '0;
            drive_pattern(MODE_LOW, MODE_LOW, MODE_LOW, EN_ALL);
            expected_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // queue first so a same-edge result still pops the oldest entry
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(commutate_word(cmd_t'(s_axis_tuser), s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata);
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing outstanding: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("compare_a", want.compare_a, got.compare_a);
                    check_field("compare_b", want.compare_b, got.compare_b);
                    check_field("compare_c", want.compare_c, got.compare_c);
                    check_field("mode_a", want.mode_a, got.mode_a);
                    check_field("mode_b", want.mode_b, got.mode_b);
                    check_field("mode_c", want.mode_c, got.mode_c);
                    check_field("output_enables", want.output_enables, got.output_enables);
                    check_field("commutation_request", want.commutation_request,
                                got.commutation_request);
                    check_field("in_idle_gap", want.in_idle_gap, got.in_idle_gap);
                    check_field("sector", want.sector, got.sector);
                    check_field("pad", want.pad, got.pad);
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

### tb/tb_six_step_commutation_pwm_unit.sv
// ----------------------------------------------------------------------------
// tb_six_step_commutation_pwm_unit: stimulus and verdict for the six-step unit
// Sends a directed walk through every sector, gap and override command with
// duty extremes, then random command streams with random gaps on both
// channels. A checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_six_step_commutation_pwm_unit;
    import ssc_pkg::*;

    localparam int RANDOM_WORDS = 1650;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [DUTY_W-1:0]   s_axis_tdata;    // [15:0] duty
    logic [1:0]          s_axis_tuser;    // [1:0] cmd
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [RESULT_W-1:0] m_axis_tdata;    // compare_a, b, c, modes, enables,
                                          // request, idle gap, sector, zero pad

    int fail_count;
    int pending;

    // Sender pacing: while calm, send back to back; otherwise insert gaps.
    int  tx_calm_left;
    bit  tx_calm;

    six_step_commutation_pwm_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ssc_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Pick a stall length: usually short, now and then a long one.
    function automatic int stall_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // Bias duty toward the values that hit truncation and saturation edges.
    function automatic logic [DUTY_W-1:0] pick_duty();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;    // most negative: clamps a plus phase at zero
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;    // -1 truncates to zero
            4:       return 16'(-31);
            5:       return 16'(-32);
            6:       return 16'd31;
            7:       return 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one command word, with an optional gap ahead of it, and hold
    // it until the unit takes it.
    task automatic send_word(input cmd_t cmd, input logic [DUTY_W-1:0] duty);
        int gap;
        if (tx_calm_left == 0)
        begin
            tx_calm_left = $urandom_range(20, 200);
            tx_calm      = ($urandom_range(0, 3) == 0);
        end
        tx_calm_left--;
        gap = (!tx_calm && $urandom_range(0, 2) == 0) ? stall_length() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= duty;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Receiver: random back-pressure with calm stretches of steady ready.
    initial
    begin
        int  hold;
        int  calm_left;
        bit  calm;
        hold          = 0;
        calm_left     = 0;
        calm          = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm_left == 0)
            begin
                calm_left = $urandom_range(50, 400);
                calm      = ($urandom_range(0, 3) == 0);
            end
            calm_left--;
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    hold = stall_length();
            end
        end
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #6000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        cmd_t cmd;
        int   roll;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_SET_DUTY;
        tx_calm_left  = 0;
        tx_calm       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk: reset state, overrides, a full sector rotation
        // with wrap from the last sector, and duty edge values on the way.
        send_word(CMD_FLOAT, 16'($urandom));        // floating out of reset
        send_word(CMD_LOW_SIDES, 16'($urandom));
        send_word(CMD_SET_DUTY, 16'h8000);          // saturates plus phases at zero
        send_word(CMD_COMMUTATE, 16'($urandom));    // leave gap, sector 1
        send_word(CMD_COMMUTATE, 16'($urandom));    // enter gap
        send_word(CMD_COMMUTATE, 16'($urandom));    // sector 2
        send_word(CMD_SET_DUTY, 16'h7FFF);
        send_word(CMD_COMMUTATE, 16'($urandom));
        send_word(CMD_COMMUTATE, 16'($urandom));    // sector 3
        send_word(CMD_SET_DUTY, 16'hFFFF);
        send_word(CMD_COMMUTATE, 16'($urandom));
        send_word(CMD_COMMUTATE, 16'($urandom));    // sector 4
        send_word(CMD_SET_DUTY, 16'd31);
        send_word(CMD_SET_DUTY, 16'(-32));
        send_word(CMD_COMMUTATE, 16'($urandom));
        send_word(CMD_COMMUTATE, 16'($urandom));    // sector 5
        send_word(CMD_FLOAT, 16'($urandom));        // outside the gap: idle flag kept
        send_word(CMD_LOW_SIDES, 16'($urandom));
        send_word(CMD_SET_DUTY, 16'(-31));
        send_word(CMD_COMMUTATE, 16'($urandom));    // gap after low sides
        send_word(CMD_COMMUTATE, 16'($urandom));    // wrap to sector 0
        send_word(CMD_SET_DUTY, 16'd32);
        send_word(CMD_COMMUTATE, 16'($urandom));
        send_word(CMD_FLOAT, 16'($urandom));        // floating inside the gap

        // Random part: mostly duty updates and commutation events, with
        // override commands mixed in and noise on unused duty bits.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 400 == 200)
                drain_results();
            roll = $urandom_range(0, 19);
            if (roll < 7)
                cmd = CMD_SET_DUTY;
            else if (roll < 16)
                cmd = CMD_COMMUTATE;
            else if (roll < 18)
                cmd = CMD_FLOAT;
            else
                cmd = CMD_LOW_SIDES;
            send_word(cmd, (cmd == CMD_SET_DUTY) ? pick_duty() : 16'($urandom));
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
hdl/ssc_pkg.sv
hdl/ssc_compare.sv
hdl/six_step_commutation_pwm_unit.sv
tb/ssc_result_checker.sv
tb/tb_six_step_commutation_pwm_unit.sv
